/* src/fefu_pkg.sv */
// ----------------------------------------------------------------------------
// fefu_pkg
// Shared constants and types for the flag/escape frame unstuffer.
// ----------------------------------------------------------------------------
package fefu_pkg;

  localparam int unsigned MAX_FRAME_BYTES_DEF = 256;

  localparam logic [7:0] FLAG_BYTE = 8'h7E;
  localparam logic [7:0] ESC_BYTE  = 8'h7D;
  localparam logic [7:0] ESC_FLAG  = 8'h5E;
  localparam logic [7:0] ESC_ESC   = 8'h5D;

  // Frame tracking flags (the byte count travels beside them).
  typedef struct packed {
    logic in_frame;
    logic start_flag;
    logic esc_pend;
  } fr_state_t;

  // Decode summary for one held byte: up to two results.
  typedef struct packed {
    logic [1:0] res_cnt;
    logic       r0_status;
    logic       r0_ok;
    logic       r1_status;
    logic       r1_ok;
  } dec_ctrl_t;

endpackage

/* src/fefu_if.sv */
// ----------------------------------------------------------------------------
// fefu_if
// Valid/ready channels for raw received bytes and for unstuffer results.
// ----------------------------------------------------------------------------
interface byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       end_of_frame;

  modport source (output valid, output rx_byte, output end_of_frame, input ready);
  modport sink   (input valid, input rx_byte, input end_of_frame, output ready);
endinterface

interface res_if #(parameter int unsigned LEN_W = 9);
  logic             valid;
  logic             ready;
  logic             is_status;
  logic [7:0]       data_byte;
  logic             frame_ok;
  logic [LEN_W-1:0] frame_length;
  logic             last_of_run;

  modport source (output valid, output is_status, output data_byte, output frame_ok,
                  output frame_length, output last_of_run, input ready);
  modport sink   (input valid, input is_status, input data_byte, input frame_ok,
                  input frame_length, input last_of_run, output ready);
endinterface

/* src/flag_escape_frame_unstuffer_unit.sv */
// ----------------------------------------------------------------------------
// flag_escape_frame_unstuffer_unit
// Byte unstuffer for flag-delimited frames: strips the flags, undoes 0x7D
// escapes and closes each frame with a status result (ok, decoded length).
//
//   channel | dir | handshake          | payload
//   in_ch   | in  | valid/ready        | rx_byte[7:0], end_of_frame
//   out_ch  | out | valid/ready        | is_status, data_byte[7:0], frame_ok,
//           |     |                    | frame_length[LEN_W-1:0], last_of_run
//
// A request lands in a holding register and is decoded there; each result
// passes through the output register, and a byte with two results (escape
// flush, or escape before an ordinary byte) stays held until both go out.
// Bytes that yield nothing retire without touching the output register.
// Reset clears the frame state and both valid flags; no clearing pass.
// Stalled output holds its result and held bytes with results; input stalls idle.
// ----------------------------------------------------------------------------
module flag_escape_frame_unstuffer_unit
  import fefu_pkg::*;
#(
  parameter int unsigned MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF,
  parameter int unsigned LEN_W           = $clog2(MAX_FRAME_BYTES + 1)
) (
  input  logic        clk,
  input  logic        rst_n,
  byte_if.sink        in_ch,
  res_if.source       out_ch
);

  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_FRAME_BYTES);

  // holding register
  logic             hold_vld_r;
  logic [7:0]       hold_byte_r;
  logic             hold_eof_r;
  logic             sel_r;
  logic             sel_nxt;

  // frame state
  fr_state_t        st_r;
  logic [LEN_W-1:0] cnt_r;

  // output register
  logic             out_vld_r;
  logic             out_status_r;
  logic [7:0]       out_data_r;
  logic             out_ok_r;
  logic [LEN_W-1:0] out_len_r;
  logic             out_last_r;

  dec_ctrl_t        ctrl;
  logic [7:0]       r0_data;
  logic [7:0]       r1_data;
  logic [LEN_W-1:0] r0_len;
  logic [LEN_W-1:0] r1_len;
  fr_state_t        st_nxt;
  logic [LEN_W-1:0] cnt_nxt;

  logic             out_free;
  logic             push;
  logic             last_push;
  logic             consume;
  logic             accept;

  fefu_dec #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES),
    .LEN_W           (LEN_W)
  ) u_dec (
    .st      (st_r),
    .cnt     (cnt_r),
    .rx_byte (hold_byte_r),
    .eof     (hold_eof_r),
    .ctrl    (ctrl),
    .r0_data (r0_data),
    .r1_data (r1_data),
    .r0_len  (r0_len),
    .r1_len  (r1_len),
    .st_nxt  (st_nxt),
    .cnt_nxt (cnt_nxt)
  );

  assign out_free  = !out_vld_r || out_ch.ready;
  assign push      = hold_vld_r && (ctrl.res_cnt != 2'd0) && out_free;
  assign last_push = sel_r || (ctrl.res_cnt == 2'd1);
  assign consume   = hold_vld_r && ((ctrl.res_cnt == 2'd0) || (push && last_push));
  assign accept    = in_ch.valid && in_ch.ready;

  assign in_ch.ready = !hold_vld_r || consume;

  always_comb begin
    sel_nxt = sel_r;
    if (consume) begin
      sel_nxt = 1'b0;
    end else if (push) begin
      sel_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_vld_r <= 1'b0;
      sel_r      <= 1'b0;
      st_r       <= '0;
      cnt_r      <= '0;
      out_vld_r  <= 1'b0;
    end else begin
      sel_r <= sel_nxt;
      if (accept) begin
        hold_vld_r <= 1'b1;
      end else if (consume) begin
        hold_vld_r <= 1'b0;
      end
      if (consume) begin
        st_r  <= st_nxt;
        cnt_r <= cnt_nxt;
      end
      if (push) begin
        out_vld_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold_byte_r <= in_ch.rx_byte;
      hold_eof_r  <= in_ch.end_of_frame;
    end
    if (push) begin
      out_last_r <= last_push;
      if (sel_r) begin
        out_status_r <= ctrl.r1_status;
        out_data_r   <= r1_data;
        out_ok_r     <= ctrl.r1_ok;
        out_len_r    <= r1_len;
      end else begin
        out_status_r <= ctrl.r0_status;
        out_data_r   <= r0_data;
        out_ok_r     <= ctrl.r0_ok;
        out_len_r    <= r0_len;
      end
    end
  end

  assign out_ch.valid        = out_vld_r;
  assign out_ch.is_status    = out_status_r;
  assign out_ch.data_byte    = out_data_r;
  assign out_ch.frame_ok     = out_ok_r;
  assign out_ch.frame_length = out_len_r;
  assign out_ch.last_of_run  = out_last_r;

  // second result only while a request is held
  a_sel_held: assert property (@(posedge clk) disable iff (!rst_n)
    sel_r |-> hold_vld_r)
    else $error("second-result select set with no held request");

  a_sel_two: assert property (@(posedge clk) disable iff (!rst_n)
    (push && sel_r) |-> (ctrl.res_cnt == 2'd2))
    else $error("second result pushed for a single-result byte");

  a_eof_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (consume && hold_eof_r) |=> (!st_r.in_frame && (cnt_r == '0)))
    else $error("frame state not cleared after closing byte");

  a_cnt_sat: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= MAX_LEN)
    else $error("decoded count beyond saturation limit");

endmodule

/* src/fefu_dec.sv */
// ----------------------------------------------------------------------------
// fefu_dec
// Decodes one held byte against the frame state: result count, the two
// candidate results and the state left behind.
// ----------------------------------------------------------------------------
module fefu_dec
  import fefu_pkg::*;
#(
  parameter int unsigned MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF,
  parameter int unsigned LEN_W           = $clog2(MAX_FRAME_BYTES + 1)
) (
  input  fr_state_t        st,
  input  logic [LEN_W-1:0] cnt,
  input  logic [7:0]       rx_byte,
  input  logic             eof,
  output dec_ctrl_t        ctrl,
  output logic [7:0]       r0_data,
  output logic [7:0]       r1_data,
  output logic [LEN_W-1:0] r0_len,
  output logic [LEN_W-1:0] r1_len,
  output fr_state_t        st_nxt,
  output logic [LEN_W-1:0] cnt_nxt
);

  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_FRAME_BYTES);

  logic [LEN_W-1:0] cnt_p1;
  logic [LEN_W-1:0] cnt_p2;
  logic             is_flag;

  assign cnt_p1  = (cnt < MAX_LEN) ? cnt + 1'b1 : cnt;
  assign cnt_p2  = (cnt_p1 < MAX_LEN) ? cnt_p1 + 1'b1 : cnt_p1;
  assign is_flag = (rx_byte == FLAG_BYTE);

  always_comb begin
    ctrl    = '0;
    r0_data = '0;
    r1_data = '0;
    r0_len  = '0;
    r1_len  = '0;
    st_nxt  = st;
    cnt_nxt = cnt;

    if (!st.in_frame) begin
      if (eof) begin
        // single byte serves as both flags
        ctrl.res_cnt   = 2'd1;
        ctrl.r0_status = 1'b1;
        ctrl.r0_ok     = is_flag;
        st_nxt         = '0;
        cnt_nxt        = '0;
      end else begin
        st_nxt.in_frame   = 1'b1;
        st_nxt.start_flag = is_flag;
        st_nxt.esc_pend   = 1'b0;
        cnt_nxt           = '0;
      end
    end else if (eof) begin
      if (st.esc_pend) begin
        // flush the dangling escape, then report
        ctrl.res_cnt   = 2'd2;
        r0_data        = ESC_BYTE;
        ctrl.r1_status = 1'b1;
        ctrl.r1_ok     = st.start_flag & is_flag;
        r1_len         = cnt_p1;
      end else begin
        ctrl.res_cnt   = 2'd1;
        ctrl.r0_status = 1'b1;
        ctrl.r0_ok     = st.start_flag & is_flag;
        r0_len         = cnt;
      end
      st_nxt  = '0;
      cnt_nxt = '0;
    end else if (st.esc_pend) begin
      st_nxt.esc_pend = 1'b0;
      if (rx_byte == ESC_FLAG) begin
        ctrl.res_cnt = 2'd1;
        r0_data      = FLAG_BYTE;
        cnt_nxt      = cnt_p1;
      end else if (rx_byte == ESC_ESC) begin
        ctrl.res_cnt = 2'd1;
        r0_data      = ESC_BYTE;
        cnt_nxt      = cnt_p1;
      end else if (rx_byte == ESC_BYTE) begin
        // emit the old escape, open a new one
        ctrl.res_cnt    = 2'd1;
        r0_data         = ESC_BYTE;
        cnt_nxt         = cnt_p1;
        st_nxt.esc_pend = 1'b1;
      end else begin
        ctrl.res_cnt = 2'd2;
        r0_data      = ESC_BYTE;
        r1_data      = rx_byte;
        cnt_nxt      = cnt_p2;
      end
    end else if (rx_byte == ESC_BYTE) begin
      st_nxt.esc_pend = 1'b1;
    end else begin
      ctrl.res_cnt = 2'd1;
      r0_data      = rx_byte;
      cnt_nxt      = cnt_p1;
    end
  end

endmodule
